// ----- hw/rtl/spq_pkg.sv -----
package spq_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     tie_lifo;
    } t_cell_ctrl;

    localparam int PRIO_BITS = 32;
    localparam int DATA_BITS = 32;
    localparam logic [2:0] ADDR_TIE_ORDER = 3'd0;

endpackage

// ----- hw/rtl/sorted_priority_queue.sv -----
// Bounded priority queue of DEPTH entries, each a signed priority and a payload tag.
// Each input transaction carries a mode: insert, remove the highest priority, or clear.
// Every input transaction produces exactly one output transaction with ok, the removed
// payload (zero unless a remove succeeded) and the number of entries held afterwards.
// Entries live in a chain of cells kept in serving order, the head cell first. An
// insert compares against every cell at once and shifts the cells behind its slot
// back by one; a remove takes the head cell and shifts every cell forward by one.
// The cell chain and the result are registered together, and a new transaction may be
// accepted in every cycle unless a stalled receiver holds the output register full.
// The input is ready whenever the output register is empty or is being emptied, so a
// stalled receiver holds the result and stops further input until it is taken.
// The tie_order register at APB byte address 0 chooses oldest first (0) or newest
// first (1) among equal priorities; the user must write it only while idle (unenforced).
// Reset empties the queue, clears tie_order and drops any pending result.
module sorted_priority_queue #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [2:0]                               paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [1:0]                               i_mode,
    input  logic signed [spq_pkg::PRIO_BITS-1:0]     i_priority_req,
    input  logic [spq_pkg::DATA_BITS-1:0]            i_payload,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic                                     o_ok,
    output logic [spq_pkg::DATA_BITS-1:0]            o_payload_out,
    output logic [$clog2(DEPTH+1)-1:0]               o_count
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                        r_tie_order;
    logic [CW-1:0]               r_held;
    logic [CW-1:0]               n_held;
    logic                        r_out_valid;
    logic                        r_ok;
    logic                        n_ok;
    logic [DATA_BITS-1:0]        r_payload_out;
    logic [DATA_BITS-1:0]        n_payload_out;

    logic                        w_take;
    logic                        w_full;
    logic                        w_empty;
    t_cell_ctrl                  w_ctrl;
    logic [63:0]                 w_in_pay64;
    logic [PAYLOAD_BITS-1:0]     w_new_payload;
    logic [63:0]                 w_head_pay64;

    logic                        w_valid [DEPTH];
    logic                        w_stays [DEPTH];
    logic signed [PRIO_BITS-1:0] w_prio  [DEPTH];
    logic [PAYLOAD_BITS-1:0]     w_pay   [DEPTH];

    assign pready = 1'b1;
    assign prdata = {31'b0, r_tie_order};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tie_order <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == ADDR_TIE_ORDER[2]) begin
            r_tie_order <= pwdata[0];
        end
    end

    assign o_in_ready    = !r_out_valid || i_out_ready;
    assign w_take        = i_in_valid && o_in_ready;
    assign w_full        = (r_held == CW'(DEPTH));
    assign w_empty       = (r_held == '0);
    assign w_in_pay64    = {32'b0, i_payload};
    assign w_new_payload = w_in_pay64[PAYLOAD_BITS-1:0];
    assign w_head_pay64  = 64'(w_pay[0]);

    always_comb begin
        w_ctrl.op       = CELL_HOLD;
        w_ctrl.tie_lifo = r_tie_order;
        n_held          = r_held;
        n_ok            = 1'b0;
        n_payload_out   = '0;
        if (w_take) begin
            unique case (t_mode'(i_mode))
                MODE_INSERT: begin
                    if (!w_full) begin
                        w_ctrl.op = CELL_INSERT;
                        n_held    = r_held + CW'(1);
                        n_ok      = 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    if (!w_empty) begin
                        w_ctrl.op     = CELL_POP;
                        n_held        = r_held - CW'(1);
                        n_ok          = 1'b1;
                        n_payload_out = w_head_pay64[DATA_BITS-1:0];
                    end
                end
                MODE_CLEAR: begin
                    n_held = '0;
                    n_ok   = 1'b1;
                end
                default: begin
                    n_held = r_held;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                        w_prev_stays;
            logic signed [PRIO_BITS-1:0] w_prev_prio;
            logic [PAYLOAD_BITS-1:0]     w_prev_pay;
            logic signed [PRIO_BITS-1:0] w_next_prio;
            logic [PAYLOAD_BITS-1:0]     w_next_pay;

            assign w_valid[gi] = (CW'(gi) < r_held);

            if (gi == 0) begin : g_head
                assign w_prev_stays = 1'b1;
                assign w_prev_prio  = i_priority_req;
                assign w_prev_pay   = w_new_payload;
            end else begin : g_body
                assign w_prev_stays = w_stays[gi-1];
                assign w_prev_prio  = w_prio[gi-1];
                assign w_prev_pay   = w_pay[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_next_prio = w_prio[gi];
                assign w_next_pay  = w_pay[gi];
            end else begin : g_link
                assign w_next_prio = w_prio[gi+1];
                assign w_next_pay  = w_pay[gi+1];
            end

            spq_cell #(
                .PAYLOAD_BITS(PAYLOAD_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (w_ctrl),
                .i_valid        (w_valid[gi]),
                .i_new_prio     (i_priority_req),
                .i_new_payload  (w_new_payload),
                .i_prev_stays   (w_prev_stays),
                .i_prev_prio    (w_prev_prio),
                .i_prev_payload (w_prev_pay),
                .i_next_prio    (w_next_prio),
                .i_next_payload (w_next_pay),
                .o_stays        (w_stays[gi]),
                .o_prio         (w_prio[gi]),
                .o_payload      (w_pay[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_held <= n_held;
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ok          <= n_ok;
            r_payload_out <= n_payload_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_payload_out = r_payload_out;
    assign o_count       = r_held;

    a_held_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(DEPTH))
        else $error("entry count exceeds the queue depth");

    a_full_insert_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_mode == MODE_INSERT && w_full |=> r_held == $past(r_held) && !r_ok)
        else $error("insert into a full queue changed the entry count");

    a_remove_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_mode == MODE_REMOVE && !w_empty |=> r_out_valid && r_ok)
        else $error("remove from a non-empty queue did not succeed");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_mode == MODE_CLEAR |=> r_held == '0 && o_count == '0)
        else $error("clear left entries in the queue");

endmodule

// ----- hw/rtl/spq_cell.sv -----
module spq_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                i_clk,
    input  spq_pkg::t_cell_ctrl                 i_ctrl,
    input  logic                                i_valid,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] i_new_prio,
    input  logic [PAYLOAD_BITS-1:0]             i_new_payload,
    input  logic                                i_prev_stays,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] i_prev_prio,
    input  logic [PAYLOAD_BITS-1:0]             i_prev_payload,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] i_next_prio,
    input  logic [PAYLOAD_BITS-1:0]             i_next_payload,
    output logic                                o_stays,
    output logic signed [spq_pkg::PRIO_BITS-1:0] o_prio,
    output logic [PAYLOAD_BITS-1:0]             o_payload
);
    import spq_pkg::*;

    logic signed [PRIO_BITS-1:0] r_prio;
    logic signed [PRIO_BITS-1:0] n_prio;
    logic [PAYLOAD_BITS-1:0]     r_payload;
    logic [PAYLOAD_BITS-1:0]     n_payload;

    // An entry stays ahead of a new one if it is served before it.
    assign o_stays = i_valid &&
                     (i_ctrl.tie_lifo ? (r_prio > i_new_prio) : (r_prio >= i_new_prio));

    always_comb begin
        n_prio    = r_prio;
        n_payload = r_payload;
        unique case (i_ctrl.op)
            CELL_INSERT: begin
                if (o_stays) begin
                    n_prio    = r_prio;
                    n_payload = r_payload;
                end else if (i_prev_stays) begin
                    n_prio    = i_new_prio;
                    n_payload = i_new_payload;
                end else begin
                    n_prio    = i_prev_prio;
                    n_payload = i_prev_payload;
                end
            end
            CELL_POP: begin
                n_prio    = i_next_prio;
                n_payload = i_next_payload;
            end
            default: begin
                n_prio    = r_prio;
                n_payload = r_payload;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

    assign o_prio    = r_prio;
    assign o_payload = r_payload;

endmodule

// ----- dv/tb_sorted_priority_queue.sv -----
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

    import spq_pkg::*;

    localparam int          QUEUE_DEPTH = 16;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int          STUCK_LIMIT = 2000;
    localparam int          PHASE_ITEMS = 230;

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] prio;
        logic [31:0]        tag;
    } t_queue_req;

    typedef struct {
        logic        ok;
        logic [31:0] tag;
        logic [4:0]  count;
    } t_queue_resp;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode         = '0;
    logic signed [31:0] i_priority_req = '0;
    logic [31:0] i_payload      = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic        o_ok;
    logic [31:0] o_payload_out;
    logic [4:0]  o_count;

    t_queue_req  req_pending[$];
    t_queue_resp resp_expected[$];

    logic signed [31:0] cell_prio[QUEUE_DEPTH];
    logic [31:0]        cell_tag[QUEUE_DEPTH];
    int                 cells_held = 0;
    logic               tie_newest = 1'b0;

    int unsigned fail_count = 0;
    int unsigned in_gap     = 0;
    int unsigned in_calm    = 0;
    int unsigned out_stall  = 0;
    int unsigned out_calm   = 0;
    int unsigned stuck      = 0;

    sorted_priority_queue #(
        .DEPTH        (QUEUE_DEPTH),
        .PAYLOAD_BITS (32)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_payload_out  (o_payload_out),
        .o_count        (o_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_queue_resp serve_request(t_queue_req r);
        t_queue_resp res;
        int          slot;
        res.ok  = 1'b0;
        res.tag = '0;
        case (r.mode)
            MODE_INSERT: begin
                if (cells_held < QUEUE_DEPTH) begin
                    slot = 0;
                    for (int i = 0; i < cells_held; i++) begin
                        if (tie_newest ? (cell_prio[i] <= r.prio) : (cell_prio[i] < r.prio))
                            slot++;
                    end
                    for (int i = cells_held; i > slot; i--) begin
                        cell_prio[i] = cell_prio[i-1];
                        cell_tag[i]  = cell_tag[i-1];
                    end
                    cell_prio[slot] = r.prio;
                    cell_tag[slot]  = r.tag;
                    cells_held++;
                    res.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (cells_held > 0) begin
                    cells_held--;
                    res.ok  = 1'b1;
                    res.tag = cell_tag[cells_held];
                end
            end
            MODE_CLEAR: begin
                cells_held = 0;
                res.ok     = 1'b1;
            end
            default: ;
        endcase
        res.count = 5'(cells_held);
        return res;
    endfunction

    function automatic int unsigned draw_gap(inout int unsigned calm);
        int unsigned pick;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_queue_req random_req(int unsigned insert_pct);
        t_queue_req  r;
        int unsigned pick;
        pick = $urandom_range(0, 199);
        if (pick < 2)
            r.mode = MODE_CLEAR;
        else if (pick < 4)
            r.mode = MODE_UNUSED;
        else if ($urandom_range(0, 99) < insert_pct)
            r.mode = MODE_INSERT;
        else
            r.mode = MODE_REMOVE;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            r.prio = $signed($urandom_range(0, 6)) - 3;
        end else if (pick < 7) begin
            r.prio = $urandom();
        end else begin
            case ($urandom_range(0, 3))
                0:       r.prio = 32'sh7FFF_FFFF;
                1:       r.prio = 32'sh8000_0000;
                2:       r.prio = 32'sh0;
                default: r.prio = -32'sd1;
            endcase
        end
        if ($urandom_range(0, 19) == 0)
            r.tag = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        else
            r.tag = $urandom();
        return r;
    endfunction

    task automatic push_req(input logic [1:0] mode, input logic signed [31:0] prio,
                            input logic [31:0] tag);
        t_queue_req r;
        r.mode = mode;
        r.prio = prio;
        r.tag  = tag;
        req_pending.push_back(r);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_pending.size() != 0 || i_in_valid || resp_expected.size() != 0);
    endtask

    task automatic write_tie_order(input logic tie);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TIE_ORDER;
        pwdata  <= {31'd0, tie};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tie_newest = tie;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_queue_req r;
        logic       busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                r.mode = i_mode;
                r.prio = i_priority_req;
                r.tag  = i_payload;
                resp_expected.push_back(serve_request(r));
                busy = 1'b0;
            end
            if (!busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (req_pending.size() != 0) begin
                    r = req_pending.pop_front();
                    i_in_valid     <= 1'b1;
                    i_mode         <= r.mode;
                    i_priority_req <= r.prio;
                    i_payload      <= r.tag;
                    in_gap = draw_gap(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_queue_resp want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (resp_expected.size() == 0) begin
                    $error("result with none expected: ok=%0b payload_out=%h count=%0d",
                           o_ok, o_payload_out, o_count);
                    fail_count++;
                end else begin
                    want = resp_expected.pop_front();
                    if (o_ok !== want.ok) begin
                        $error("ok: expected %0b, got %0b", want.ok, o_ok);
                        fail_count++;
                    end
                    if (o_payload_out !== want.tag) begin
                        $error("payload_out: expected %h, got %h", want.tag, o_payload_out);
                        fail_count++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_count);
                        fail_count++;
                    end
                end
                out_stall = draw_gap(out_calm);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= STUCK_LIMIT) begin
            $display("[sorted_priority_queue] ERROR");
            $finish;
        end
    end

    initial begin
        logic        phase_ties[6];
        int unsigned insert_pct;
        phase_ties = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_tie_order(1'b0);
        push_req(MODE_REMOVE, 32'sh0, 32'h1234_5678);
        push_req(MODE_UNUSED, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        push_req(MODE_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        push_req(MODE_INSERT, 32'sh8000_0000, 32'h0);
        push_req(MODE_INSERT, 32'sh0, 32'hA5A5_A5A5);
        push_req(MODE_INSERT, 32'sh0, 32'h5A5A_5A5A);
        push_req(MODE_INSERT, -32'sd1, 32'h0F0F_0F0F);
        push_req(MODE_REMOVE, 32'sh0, 32'h0);
        push_req(MODE_REMOVE, 32'sh0, 32'h0);
        push_req(MODE_REMOVE, 32'sh0, 32'h0);
        push_req(MODE_CLEAR, 32'sh0, 32'h0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            push_req(MODE_INSERT, $signed($urandom_range(0, 4)) - 2, $urandom());
        push_req(MODE_INSERT, 32'sh7FFF_FFFF, 32'hDEAD_BEEF);
        push_req(MODE_CLEAR, 32'sh0, 32'h0);
        wait_drained();

        write_tie_order(1'b1);
        push_req(MODE_INSERT, 32'sd5, 32'h0000_00AA);
        push_req(MODE_INSERT, 32'sd5, 32'h0000_00BB);
        push_req(MODE_INSERT, 32'sd2, 32'h0000_00CC);
        push_req(MODE_REMOVE, 32'sh0, 32'h0);
        wait_drained();

        foreach (phase_ties[p]) begin
            write_tie_order(phase_ties[p]);
            insert_pct = 50;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 29) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       insert_pct = 25;
                        1:       insert_pct = 50;
                        2:       insert_pct = 75;
                        default: insert_pct = 92;
                    endcase
                end
                req_pending.push_back(random_req(insert_pct));
            end
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("[sorted_priority_queue] OK");
        else
            $display("[sorted_priority_queue] ERROR");
        $finish;
    end

endmodule
